>>> rtl/fir_lc_pkg.sv
`default_nettype none

package fir_lc_pkg;

    localparam int DATA_W     = 16;
    localparam int IDX_W      = 4;
    localparam int CFG_W      = 5;
    localparam int PROD_W     = 2 * DATA_W;
    localparam int RES_W      = 40;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 40;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    localparam logic [CFG_W-1:0] TAPS_RESET = 5'd1;

    typedef struct packed {
        logic valid;
        logic last;
    } t_stage_ctl;

endpackage

`default_nettype wire

>>> rtl/fir_lc_taps.sv
`default_nettype none

module fir_lc_taps #(
    parameter int MAX_TAPS = 16
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_cfg_wen,
    input  wire logic [fir_lc_pkg::CFG_W-1:0]          i_cfg_wdata,
    input  wire logic                                  i_adv,
    input  wire logic                                  i_s_tvalid,
    output logic                                       o_s_tready,
    input  wire logic                                  i_cmd,
    input  wire logic [fir_lc_pkg::IDX_W-1:0]          i_coef_index,
    input  wire logic signed [fir_lc_pkg::DATA_W-1:0]  i_value,
    input  wire logic                                  i_last,
    output logic signed [fir_lc_pkg::PROD_W-1:0]       o_prod [MAX_TAPS],
    output fir_lc_pkg::t_stage_ctl                     o_ctl
);

    localparam int TW   = $clog2(MAX_TAPS + 1);
    localparam int CIDX = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;

    logic [fir_lc_pkg::CFG_W-1:0]         r_taps;
    logic [TW-1:0]                        r_flush;
    logic [TW-1:0]                        n_flush;
    logic [TW-1:0]                        n_eff;
    logic signed [fir_lc_pkg::DATA_W-1:0] r_dl   [MAX_TAPS];
    logic signed [fir_lc_pkg::DATA_W-1:0] r_kern [MAX_TAPS];
    logic signed [fir_lc_pkg::DATA_W-1:0] n_dl   [MAX_TAPS];
    logic signed [fir_lc_pkg::PROD_W-1:0] r_prod [MAX_TAPS];
    fir_lc_pkg::t_stage_ctl               r_ctl;

    logic            accept;
    logic            step_sample;
    logic            step_flush;
    logic            do_shift;
    logic            final_step;
    logic            kern_wr;
    logic [CIDX-1:0] kidx;
    logic            dl_zero;

    // effective tap count: zero means one, clamp to the line length
    always_comb begin
        if (r_taps == '0) begin
            n_eff = TW'(1);
        end else if (int'(r_taps) > MAX_TAPS) begin
            n_eff = TW'(MAX_TAPS);
        end else begin
            n_eff = TW'(r_taps);
        end
    end

    assign o_s_tready  = i_adv && (r_flush == '0);
    assign accept      = i_s_tvalid && o_s_tready;
    assign step_sample = accept && (i_cmd == fir_lc_pkg::CMD_SAMPLE);
    assign step_flush  = i_adv && (r_flush != '0);
    assign do_shift    = step_sample || step_flush;
    assign final_step  = (step_sample && i_last && (n_eff == TW'(1)))
                      || (step_flush && (r_flush == TW'(1)));
    assign kern_wr     = accept && (i_cmd == fir_lc_pkg::CMD_LOAD)
                      && (int'(i_coef_index) < MAX_TAPS);
    assign kidx        = CIDX'(i_coef_index);

    always_comb begin
        n_dl[0] = step_flush ? '0 : i_value;
        for (int k = 1; k < MAX_TAPS; k++) begin
            n_dl[k] = r_dl[k-1];
        end
    end

    always_comb begin
        n_flush = r_flush;
        if (step_sample && i_last && (n_eff != TW'(1))) begin
            n_flush = n_eff - TW'(1);
        end else if (step_flush) begin
            n_flush = r_flush - TW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_taps  <= fir_lc_pkg::TAPS_RESET;
            r_flush <= '0;
            r_ctl   <= '0;
            for (int k = 0; k < MAX_TAPS; k++) begin
                r_dl[k]   <= '0;
                r_kern[k] <= '0;
            end
        end else begin
            if (i_cfg_wen) begin
                r_taps <= i_cfg_wdata;
            end
            r_flush <= n_flush;
            if (i_adv) begin
                r_ctl.valid <= do_shift;
                r_ctl.last  <= final_step;
            end
            for (int k = 0; k < MAX_TAPS; k++) begin
                if (do_shift) begin
                    // the line is emptied once the final word of a run is formed
                    r_dl[k] <= final_step ? '0 : n_dl[k];
                end
                if (kern_wr && (kidx == CIDX'(k))) begin
                    r_kern[k] <= i_value;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int k = 0; k < MAX_TAPS; k++) begin
                if (k < int'(n_eff)) begin
                    r_prod[k] <= n_dl[k] * r_kern[k];
                end else begin
                    r_prod[k] <= '0;
                end
            end
        end
    end

    assign o_prod = r_prod;
    assign o_ctl  = r_ctl;

    always_comb begin
        dl_zero = 1'b1;
        for (int k = 0; k < MAX_TAPS; k++) begin
            if (r_dl[k] != '0) begin
                dl_zero = 1'b0;
            end
        end
    end

    a_line_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        final_step |=> dl_zero)
        else $error("delay line not cleared after final word");

    a_flush_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_flush) < MAX_TAPS)
        else $error("flush count out of range");

    a_flush_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step_sample && i_last && (n_eff != TW'(1)))
        |=> (r_flush == $past(n_eff) - TW'(1)))
        else $error("flush count not loaded from tap count");

endmodule

`default_nettype wire

>>> rtl/fir_lc_sum.sv
`default_nettype none

module fir_lc_sum #(
    parameter int MAX_TAPS = 16
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic signed [fir_lc_pkg::PROD_W-1:0]  i_prod [MAX_TAPS],
    input  wire fir_lc_pkg::t_stage_ctl                i_ctl,
    output logic                                       o_adv,
    output logic                                       o_m_tvalid,
    input  wire logic                                  i_m_tready,
    output logic signed [fir_lc_pkg::RES_W-1:0]        o_result,
    output logic                                       o_last
);

    localparam int NG = (MAX_TAPS + 3) / 4;

    logic signed [fir_lc_pkg::RES_W-1:0] r_part [NG];
    logic signed [fir_lc_pkg::RES_W-1:0] n_part [NG];
    logic signed [fir_lc_pkg::RES_W-1:0] n_total;
    logic signed [fir_lc_pkg::RES_W-1:0] r_out;
    fir_lc_pkg::t_stage_ctl              r_ctl1;
    fir_lc_pkg::t_stage_ctl              r_ctl_out;

    // whole pipe moves when the output register is empty or being taken
    assign o_adv = !r_ctl_out.valid || i_m_tready;

    // groups of four products per partial sum
    always_comb begin
        for (int g = 0; g < NG; g++) begin
            n_part[g] = '0;
            for (int j = 0; j < 4; j++) begin
                if (g * 4 + j < MAX_TAPS) begin
                    n_part[g] = n_part[g] + fir_lc_pkg::RES_W'(i_prod[g * 4 + j]);
                end
            end
        end
    end

    always_comb begin
        n_total = '0;
        for (int g = 0; g < NG; g++) begin
            n_total = n_total + r_part[g];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1    <= '0;
            r_ctl_out <= '0;
        end else if (o_adv) begin
            r_ctl1    <= i_ctl;
            r_ctl_out <= r_ctl1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_part <= n_part;
            r_out  <= n_total;
        end
    end

    assign o_m_tvalid = r_ctl_out.valid;
    assign o_result   = r_out;
    assign o_last     = r_ctl_out.last;

    a_hold_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ctl1.valid && !o_adv) |=> r_ctl1.valid)
        else $error("partial sum word lost during stall");

endmodule

`default_nettype wire

>>> rtl/fir_linear_convolution.sv
// channel   dir  handshake               payload
// s_axis    in   i_s_tvalid/o_s_tready   tdata: coef_index, value; tuser: command; tlast
// m_axis    out  o_m_tvalid/i_m_tready   tdata: result_value; tlast: last_result
// cfg       in   i_cfg_wen               i_cfg_wdata: tap_count
//
// one word accepted per cycle while tready is high; products and sums are registered
// tlast on a sample drops tready during a tail flush of n-1 zero words (n: clamped tap_count)
// the product register, partial sums and output register advance together; a stall
// on m_axis freezes all of them and drops tready in the same cycle
// reset (synchronous, active low) clears the delay line and kernel, sets tap_count to one
`default_nettype none

module fir_linear_convolution #(
    parameter int MAX_TAPS = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_wen,
    input  wire logic [fir_lc_pkg::CFG_W-1:0]        i_cfg_wdata,
    input  wire logic                                i_s_tvalid,
    output logic                                     o_s_tready,
    // [3:0] coef_index, [19:4] value, [23:20] zero
    input  wire logic [fir_lc_pkg::S_TDATA_W-1:0]    i_s_tdata,
    // [0] command
    input  wire logic                                i_s_tuser,
    input  wire logic                                i_s_tlast,
    output logic                                     o_m_tvalid,
    input  wire logic                                i_m_tready,
    // [39:0] result_value
    output logic [fir_lc_pkg::M_TDATA_W-1:0]         o_m_tdata,
    output logic                                     o_m_tlast
);

    logic                                 adv;
    logic signed [fir_lc_pkg::DATA_W-1:0] value;
    logic [fir_lc_pkg::IDX_W-1:0]         coef_index;
    logic signed [fir_lc_pkg::PROD_W-1:0] prod [MAX_TAPS];
    fir_lc_pkg::t_stage_ctl               prod_ctl;
    logic signed [fir_lc_pkg::RES_W-1:0]  result;

    assign coef_index = i_s_tdata[fir_lc_pkg::IDX_W-1:0];
    assign value      = i_s_tdata[fir_lc_pkg::IDX_W +: fir_lc_pkg::DATA_W];

    fir_lc_taps #(
        .MAX_TAPS (MAX_TAPS)
    ) u_taps (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wen    (i_cfg_wen),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_adv        (adv),
        .i_s_tvalid   (i_s_tvalid),
        .o_s_tready   (o_s_tready),
        .i_cmd        (i_s_tuser),
        .i_coef_index (coef_index),
        .i_value      (value),
        .i_last       (i_s_tlast),
        .o_prod       (prod),
        .o_ctl        (prod_ctl)
    );

    fir_lc_sum #(
        .MAX_TAPS (MAX_TAPS)
    ) u_sum (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_prod     (prod),
        .i_ctl      (prod_ctl),
        .o_adv      (adv),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_result   (result),
        .o_last     (o_m_tlast)
    );

    assign o_m_tdata = fir_lc_pkg::M_TDATA_W'(result);

endmodule

`default_nettype wire

>>> tb/testbench.sv
`default_nettype none

module testbench;

    localparam int TAPS_MAX     = 16;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 24;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_ITEMS  = 50;

    typedef struct packed {
        logic                                 cmd;
        logic [fir_lc_pkg::IDX_W-1:0]         idx;
        logic signed [fir_lc_pkg::DATA_W-1:0] value;
        logic                                 last;
    } t_word;

    typedef struct packed {
        logic [fir_lc_pkg::RES_W-1:0] value;
        logic                         last;
    } t_result;

    typedef enum int {RX_FREE, RX_HALF, RX_SPARSE, RX_MOSTLY} t_rx_mode;

    logic                             i_clk       = 1'b0;
    logic                             i_rst_n     = 1'b0;
    logic                             cfg_wen     = 1'b0;
    logic [fir_lc_pkg::CFG_W-1:0]     cfg_wdata   = '0;
    logic                             s_tvalid    = 1'b0;
    logic                             s_tready;
    logic [fir_lc_pkg::S_TDATA_W-1:0] s_tdata     = '0;
    logic                             s_tuser     = 1'b0;
    logic                             s_tlast     = 1'b0;
    logic                             m_tvalid;
    logic                             m_tready    = 1'b0;
    logic [fir_lc_pkg::M_TDATA_W-1:0] m_tdata;
    logic                             m_tlast;

    fir_linear_convolution #(.MAX_TAPS(TAPS_MAX)) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (cfg_wen),
        .i_cfg_wdata (cfg_wdata),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .i_s_tlast   (s_tlast),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tlast   (m_tlast)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // shadow of the filter state
    logic signed [fir_lc_pkg::DATA_W-1:0] coef_mem [TAPS_MAX];
    logic signed [fir_lc_pkg::DATA_W-1:0] line_mem [TAPS_MAX];
    logic [fir_lc_pkg::CFG_W-1:0]         taps_reg;

    t_word   send_q[$];
    t_result pending_results[$];

    int mismatch_count = 0;
    int cycle_count    = 0;
    int hold_req       = 0;
    int hold_done      = 0;

    task automatic shift_line(input logic signed [fir_lc_pkg::DATA_W-1:0] s);
        int k;
        for (k = TAPS_MAX - 1; k > 0; k--) line_mem[k] = line_mem[k-1];
        line_mem[0] = s;
    endtask

    function automatic logic [fir_lc_pkg::RES_W-1:0] line_dot(input int n);
        longint acc;
        int k;
        acc = 0;
        for (k = 0; k < n; k++) acc += longint'(line_mem[k]) * longint'(coef_mem[k]);
        return acc[fir_lc_pkg::RES_W-1:0];
    endfunction

    task automatic absorb_word(input t_word w);
        int n;
        int k;
        t_result r;
        if (w.cmd == fir_lc_pkg::CMD_LOAD) begin
            coef_mem[w.idx] = w.value;
        end else begin
            n = (taps_reg == 0) ? 1 : (taps_reg > TAPS_MAX) ? TAPS_MAX : int'(taps_reg);
            shift_line(w.value);
            r.value = line_dot(n);
            r.last  = w.last && (n == 1);
            pending_results.push_back(r);
            if (w.last) begin
                // flush the tail with zeros, then clear the line
                for (k = 1; k < n; k++) begin
                    shift_line('0);
                    r.value = line_dot(n);
                    r.last  = (k == n - 1);
                    pending_results.push_back(r);
                end
                for (k = 0; k < TAPS_MAX; k++) line_mem[k] = '0;
            end
        end
    endtask

    always @(posedge i_clk) begin : predict_proc
        t_word w;
        int k;
        if (!i_rst_n) begin
            taps_reg = fir_lc_pkg::TAPS_RESET;
            for (k = 0; k < TAPS_MAX; k++) begin
                coef_mem[k] = '0;
                line_mem[k] = '0;
            end
        end else begin
            if (cfg_wen) taps_reg = cfg_wdata;
            if (s_tvalid && s_tready) begin
                w.cmd   = s_tuser;
                w.idx   = s_tdata[fir_lc_pkg::IDX_W-1:0];
                w.value = s_tdata[fir_lc_pkg::IDX_W+fir_lc_pkg::DATA_W-1:fir_lc_pkg::IDX_W];
                w.last  = s_tlast;
                absorb_word(w);
            end
        end
    end

    task automatic report_mismatch(input string what, input t_result e);
        if (mismatch_count < 10)
            $display("%s: expected value %0d last %0b, got value %0d last %0b",
                     what, $signed(e.value), e.last, $signed(m_tdata), m_tlast);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin : monitor_proc
        t_result e;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                e = '0;
                report_mismatch("unexpected word", e);
            end else begin
                e = pending_results.pop_front();
                if (m_tdata !== e.value || m_tlast !== e.last)
                    report_mismatch("mismatch", e);
            end
        end
    end

    // sender: bursts of random length separated by random gaps
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge i_clk) begin : drive_proc
        t_word w;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (send_q.size() > 0) begin
                w = send_q.pop_front();
                s_tdata  <= {{(fir_lc_pkg::S_TDATA_W-fir_lc_pkg::IDX_W-fir_lc_pkg::DATA_W){1'b0}},
                             w.value, w.idx};
                s_tuser  <= w.cmd;
                s_tlast  <= w.last;
                s_tvalid <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 40);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: stall pattern switching between modes, plus long hold-offs on request
    t_rx_mode rx_mode   = RX_FREE;
    int       rx_left   = 0;
    int       hold_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (hold_done != hold_req) begin
            hold_done = hold_req;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode = t_rx_mode'($urandom_range(0, 3));
                rx_left = $urandom_range(4, 60);
            end
            rx_left--;
            case (rx_mode)
                RX_FREE:   m_tready <= 1'b1;
                RX_HALF:   m_tready <= ($urandom_range(0, 1) == 1);
                RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
                default:   m_tready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic queue_word(input logic cmd, input int idx,
                              input logic signed [fir_lc_pkg::DATA_W-1:0] value,
                              input logic last);
        t_word w;
        w.cmd   = cmd;
        w.idx   = idx[fir_lc_pkg::IDX_W-1:0];
        w.value = value;
        w.last  = last;
        send_q.push_back(w);
    endtask

    function automatic logic signed [fir_lc_pkg::DATA_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2:       return 16'sh0000;
            3:       return 16'shffff;
            default: return 16'($urandom);
        endcase
    endfunction

    // sender pauses until every result is back, then lets the pipeline drain
    task automatic wait_idle();
        do @(posedge i_clk);
        while (send_q.size() != 0 || s_tvalid || pending_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_taps(input int v);
        @(posedge i_clk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= v[fir_lc_pkg::CFG_W-1:0];
        @(posedge i_clk);
        cfg_wen   <= 1'b0;
    endtask

    // mostly well-formed runs ending in tlast, some kernel reloads and some noise
    task automatic random_phase(input int n_items);
        int pushed;
        int len;
        int j;
        int r;
        pushed = 0;
        while (pushed < n_items) begin
            r = $urandom_range(0, 9);
            if (r < 2) begin
                len = $urandom_range(1, 16);
                for (j = 0; j < len; j++)
                    queue_word(fir_lc_pkg::CMD_LOAD, $urandom_range(0, 15), pick_value(),
                               1'($urandom_range(0, 1)));
                pushed += len;
            end else if (r < 9) begin
                len = $urandom_range(1, 12);
                for (j = 0; j < len; j++) begin
                    // a kernel update in the middle of a run now and then
                    if ($urandom_range(0, 15) == 0) begin
                        queue_word(fir_lc_pkg::CMD_LOAD, $urandom_range(0, 15), pick_value(),
                                   1'b0);
                        pushed++;
                    end
                    queue_word(fir_lc_pkg::CMD_SAMPLE, $urandom_range(0, 15), pick_value(),
                               j == len - 1);
                end
                pushed += len;
            end else begin
                queue_word(1'($urandom_range(0, 1)), $urandom_range(0, 15), pick_value(),
                           1'($urandom_range(0, 1)));
                pushed++;
            end
        end
    endtask

    initial begin : sequence_proc
        int taps_plan[8];
        int p;
        int k;
        taps_plan = '{16, 0, 31, 17, 2, 1, 8, 3};
        taps_plan[7] = $urandom_range(3, 15);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // single tap: empty kernel, last flag on a load, single-tap last
        write_taps(1);
        queue_word(fir_lc_pkg::CMD_SAMPLE, 15, 16'sd100, 1'b0);
        queue_word(fir_lc_pkg::CMD_LOAD, 0, 16'sh8000, 1'b1);
        queue_word(fir_lc_pkg::CMD_SAMPLE, 0, 16'sh8000, 1'b0);
        queue_word(fir_lc_pkg::CMD_SAMPLE, 5, 16'sh7fff, 1'b1);
        queue_word(fir_lc_pkg::CMD_SAMPLE, 10, 16'shffff, 1'b0);
        wait_idle();

        // full length, tail flush
        write_taps(16);
        queue_word(fir_lc_pkg::CMD_LOAD, 15, 16'sh7fff, 1'b0);
        queue_word(fir_lc_pkg::CMD_LOAD, 0, 16'shffff, 1'b0);
        queue_word(fir_lc_pkg::CMD_SAMPLE, 3, 16'sh7fff, 1'b0);
        queue_word(fir_lc_pkg::CMD_SAMPLE, 12, 16'sh8000, 1'b1);
        wait_idle();

        for (p = 0; p < 8; p++) begin
            write_taps(taps_plan[p]);
            if (p == 0) begin
                // largest accumulator magnitude: every product at its maximum
                for (k = 0; k < TAPS_MAX; k++)
                    queue_word(fir_lc_pkg::CMD_LOAD, k, 16'sh8000, 1'b0);
                for (k = 0; k < TAPS_MAX; k++)
                    queue_word(fir_lc_pkg::CMD_SAMPLE, k, 16'sh8000, k == TAPS_MAX - 1);
            end
            random_phase(PHASE_ITEMS);
            // hold the output off while words keep coming, so the input stalls
            if (p == 0 || p == 4) hold_req++;
            wait_idle();
        end

        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
